>>> src/bsab_pkg.sv
package bsab_pkg;

   // default store geometry
   localparam int MAX_W_DEF = 256;
   localparam int MAX_H_DEF = 256;

   // width of the integer part of a scaled coordinate
   localparam int COORD_W = 13;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_BLEND = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      REG_SMALL_WIDTH      = 3'd0,
      REG_SMALL_HEIGHT     = 3'd1,
      REG_X_STEP           = 3'd2,
      REG_Y_STEP           = 3'd3,
      REG_BLEND_WEIGHT     = 3'd4,
      REG_WEIGHT_ON_STREAM = 3'd5
   } csr_index_type;

   // per-stage load enables of the channel lanes
   typedef struct packed {
      logic ld3;
      logic ld4;
      logic ld5;
   } lane_ctl_type;

   // linear interpolation of two bytes by a q8 fraction, truncated
   function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] f);
      logic [16:0] acc;
      acc = 17'(a) * 17'(9'd256 - {1'b0, f}) + 17'(b) * 17'(f);
      return acc[15:8];
   endfunction

endpackage

>>> src/bsab_if.sv
interface bsab_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   logic [7:0]  blue_in;
   logic [7:0]  green_in;
   logic [7:0]  red_in;

   modport source(output valid, operation, pixel_x, pixel_y, blue_in, green_in, red_in,
                  input ready);
   modport sink(input valid, operation, pixel_x, pixel_y, blue_in, green_in, red_in,
                output ready);
endinterface

interface bsab_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue_out;
   logic [7:0] green_out;
   logic [7:0] red_out;

   modport source(output valid, blue_out, green_out, red_out, input ready);
   modport sink(input valid, blue_out, green_out, red_out, output ready);
endinterface

>>> src/bsab_store.sv
module bsab_store #(
   parameter int AW = 14
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [1:0]           wr_bank,
   input  logic [AW-1:0]        wr_addr,
   input  logic [23:0]          wr_data,
   input  logic                 rd_en,
   input  logic [3:0][AW-1:0]   rd_addr,
   output logic [3:0][23:0]     rd_data
);

   localparam int DEPTH = 2 ** AW;

   // four banks split by row and column parity, one read each per cycle while rd_en is set
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [23:0] mem [DEPTH];
      logic [23:0] rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en && wr_bank == 2'(b)) begin
            mem[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rd_ff <= mem[rd_addr[b]];
         end
      end

      assign rd_data[b] = rd_ff;
   end

endmodule

>>> src/bsab_lane.sv
module bsab_lane import bsab_pkg::*; (
   input  logic         clock,
   input  lane_ctl_type ctl,
   input  logic [7:0]   p11,
   input  logic [7:0]   p12,
   input  logic [7:0]   p21,
   input  logic [7:0]   p22,
   input  logic [7:0]   fx,
   input  logic [7:0]   fy,
   input  logic [7:0]   stream,
   input  logic [8:0]   weight,
   input  logic         on_stream,
   output logic [7:0]   result
);

   logic [7:0]  left_ff, right_ff, fx3_ff, str3_ff;
   logic [7:0]  samp_ff, str4_ff;
   logic [7:0]  out_ff;
   logic [7:0]  mix_a, mix_b;
   logic [16:0] mix_acc;

   // vertical interpolation of both columns
   always_ff @(posedge clock) begin
      if (ctl.ld3) begin
         left_ff  <= lerp8(p11, p12, fy);
         right_ff <= lerp8(p21, p22, fy);
         fx3_ff   <= fx;
         str3_ff  <= stream;
      end
   end

   // horizontal interpolation
   always_ff @(posedge clock) begin
      if (ctl.ld4) begin
         samp_ff <= lerp8(left_ff, right_ff, fx3_ff);
         str4_ff <= str3_ff;
      end
   end

   // weighted mix with the streamed pixel
   always_comb begin
      mix_a   = on_stream ? str4_ff : samp_ff;
      mix_b   = on_stream ? samp_ff : str4_ff;
      mix_acc = 17'(mix_a) * 17'(weight) + 17'(mix_b) * 17'(9'd256 - weight);
   end

   always_ff @(posedge clock) begin
      if (ctl.ld5) begin
         out_ff <= mix_acc[15:8];
      end
   end

   assign result = out_ff;

endmodule

>>> src/bilinear_scale_alpha_blend.sv
// bilinear upscale with alpha blend
// req_chan: valid/ready items. operation load writes a pixel of the small
//   image into the banked on-chip store (dropped outside the configured size);
//   operation blend scales the coordinate, samples the store bilinearly and
//   mixes the sample with the item's pixel. loads give no result.
// rsp_chan: one blended bgr pixel per blend item, in order.
// csr: apb-style write/read of size, q16 steps, q8 weight and weight side.
// throughput: one item per cycle unless the output stalls. the four parity
//   banks let all four neighbors be read together, one port per bank.
// stages: five (scale multiply, store read, vertical lerp, horizontal lerp,
//   mix), in that order; the result is registered in the mix stage.
// stalls: each stage moves when the next one is empty or moving, so bubbles
//   close up; items enter while any stage is empty, even if rsp ready is low.
// reset: pipeline emptied and registers set to their defaults; the store is
//   not cleared and must be loaded before it is sampled.
module bilinear_scale_alpha_blend import bsab_pkg::*; #(
   parameter int MAX_SMALL_WIDTH  = MAX_W_DEF,
   parameter int MAX_SMALL_HEIGHT = MAX_H_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bsab_req_if.sink    req_chan,
   bsab_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int XW  = $clog2(MAX_SMALL_WIDTH);
   localparam int YW  = $clog2(MAX_SMALL_HEIGHT);
   localparam int CXW = (XW > 1) ? XW - 1 : 1;
   localparam int CYW = (YW > 1) ? YW - 1 : 1;
   localparam int AW  = CXW + CYW;

   // configuration registers
   logic [8:0]  small_width_ff, small_height_ff, blend_weight_ff;
   logic [16:0] x_step_ff, y_step_ff;
   logic        weight_on_stream_ff;
   logic        csr_wr;
   csr_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         small_width_ff      <= 9'd256;
         small_height_ff     <= 9'd256;
         x_step_ff           <= 17'd65536;
         y_step_ff           <= 17'd65536;
         blend_weight_ff     <= 9'd128;
         weight_on_stream_ff <= 1'b1;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_SMALL_WIDTH:      small_width_ff      <= csr_pwdata[8:0];
            REG_SMALL_HEIGHT:     small_height_ff     <= csr_pwdata[8:0];
            REG_X_STEP:           x_step_ff           <= csr_pwdata[16:0];
            REG_Y_STEP:           y_step_ff           <= csr_pwdata[16:0];
            REG_BLEND_WEIGHT:     blend_weight_ff     <= csr_pwdata[8:0];
            REG_WEIGHT_ON_STREAM: weight_on_stream_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SMALL_WIDTH:      csr_prdata = {23'd0, small_width_ff};
         REG_SMALL_HEIGHT:     csr_prdata = {23'd0, small_height_ff};
         REG_X_STEP:           csr_prdata = {15'd0, x_step_ff};
         REG_Y_STEP:           csr_prdata = {15'd0, y_step_ff};
         REG_BLEND_WEIGHT:     csr_prdata = {23'd0, blend_weight_ff};
         REG_WEIGHT_ON_STREAM: csr_prdata = {31'd0, weight_on_stream_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   // effective size and weight
   logic [COORD_W-1:0] w_eff, h_eff, w_last, h_last;
   logic [8:0]         wt;

   always_comb begin
      if (small_width_ff == 9'd0) begin
         w_eff = COORD_W'(1);
      end else if (COORD_W'(small_width_ff) > COORD_W'(MAX_SMALL_WIDTH)) begin
         w_eff = COORD_W'(MAX_SMALL_WIDTH);
      end else begin
         w_eff = COORD_W'(small_width_ff);
      end
      if (small_height_ff == 9'd0) begin
         h_eff = COORD_W'(1);
      end else if (COORD_W'(small_height_ff) > COORD_W'(MAX_SMALL_HEIGHT)) begin
         h_eff = COORD_W'(MAX_SMALL_HEIGHT);
      end else begin
         h_eff = COORD_W'(small_height_ff);
      end
      w_last = w_eff - COORD_W'(1);
      h_last = h_eff - COORD_W'(1);
      wt     = (blend_weight_ff > 9'd256) ? 9'd256 : blend_weight_ff;
   end

   // stage handshake: a stage loads when empty or when the next one loads
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic ld1, ld2, ld3, ld4, ld5;

   assign ld5 = !v5_ff || rsp_chan.ready;
   assign ld4 = !v4_ff || ld5;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign req_chan.ready = ld1;

   op_type op1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= req_chan.valid;
         if (ld2) v2_ff <= v1_ff && op1_ff == OP_BLEND;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v3_ff;
         if (ld5) v5_ff <= v4_ff;
      end
   end

   // stage 1: scale the coordinate
   logic [11:0] px1_ff, py1_ff;
   logic [23:0] pix1_ff;
   logic [28:0] sx1_ff, sy1_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         op1_ff  <= op_type'(req_chan.operation);
         px1_ff  <= req_chan.pixel_x;
         py1_ff  <= req_chan.pixel_y;
         pix1_ff <= {req_chan.red_in, req_chan.green_in, req_chan.blue_in};
         sx1_ff  <= 29'(req_chan.pixel_x) * 29'(x_step_ff);
         sy1_ff  <= 29'(req_chan.pixel_y) * 29'(y_step_ff);
      end
   end

   // clamp neighbors and form bank addresses
   logic [COORD_W-1:0] xi, yi, x1c, y1c, x2c, y2c;
   logic [XW-1:0]      x1, x2, wx;
   logic [YW-1:0]      y1, y2, wy;
   logic [3:0][AW-1:0] rd_addr;
   logic [CXW-1:0]     bcol;
   logic [CYW-1:0]     brow;
   logic               wr_en;

   always_comb begin
      xi  = sx1_ff[28:16];
      yi  = sy1_ff[28:16];
      x1c = (xi > w_last) ? w_last : xi;
      y1c = (yi > h_last) ? h_last : yi;
      x2c = (x1c == w_last) ? x1c : x1c + COORD_W'(1);
      y2c = (y1c == h_last) ? y1c : y1c + COORD_W'(1);
      x1  = x1c[XW-1:0];
      x2  = x2c[XW-1:0];
      y1  = y1c[YW-1:0];
      y2  = y2c[YW-1:0];
      for (int b = 0; b < 4; b++) begin
         bcol = (x1[0] == b[0]) ? CXW'(x1 >> 1) : CXW'(x2 >> 1);
         brow = (y1[0] == b[1]) ? CYW'(y1 >> 1) : CYW'(y2 >> 1);
         rd_addr[b] = {brow, bcol};
      end
      wx    = px1_ff[XW-1:0];
      wy    = py1_ff[YW-1:0];
      wr_en = v1_ff && op1_ff == OP_LOAD &&
              COORD_W'(px1_ff) < w_eff && COORD_W'(py1_ff) < h_eff;
   end

   logic [3:0][23:0] bank_data;

   bsab_store #(
      .AW(AW)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_bank({wy[0], wx[0]}),
      .wr_addr({CYW'(wy >> 1), CXW'(wx >> 1)}),
      .wr_data(pix1_ff),
      .rd_en  (ld2),
      .rd_addr(rd_addr),
      .rd_data(bank_data)
   );

   // stage 2: fractions and parities travel with the store read
   logic [7:0]  fx2_ff, fy2_ff;
   logic        x1p_ff, x2p_ff, y1p_ff, y2p_ff;
   logic [23:0] pix2_ff;

   always_ff @(posedge clock) begin
      if (ld2) begin
         fx2_ff  <= sx1_ff[15:8];
         fy2_ff  <= sy1_ff[15:8];
         x1p_ff  <= x1[0];
         x2p_ff  <= x2[0];
         y1p_ff  <= y1[0];
         y2p_ff  <= y2[0];
         pix2_ff <= pix1_ff;
      end
   end

   // one lane per color channel
   lane_ctl_type    lane_ctl;
   logic [2:0][7:0] lane_res;

   assign lane_ctl = '{ld3: ld3, ld4: ld4, ld5: ld5};

   for (genvar c = 0; c < 3; c++) begin : g_lane
      bsab_lane u_lane (
         .clock    (clock),
         .ctl      (lane_ctl),
         .p11      (bank_data[{y1p_ff, x1p_ff}][8*c +: 8]),
         .p12      (bank_data[{y2p_ff, x1p_ff}][8*c +: 8]),
         .p21      (bank_data[{y1p_ff, x2p_ff}][8*c +: 8]),
         .p22      (bank_data[{y2p_ff, x2p_ff}][8*c +: 8]),
         .fx       (fx2_ff),
         .fy       (fy2_ff),
         .stream   (pix2_ff[8*c +: 8]),
         .weight   (wt),
         .on_stream(weight_on_stream_ff),
         .result   (lane_res[c])
      );
   end

   // merge lanes into the result item
   assign rsp_chan.valid     = v5_ff;
   assign rsp_chan.blue_out  = lane_res[0];
   assign rsp_chan.green_out = lane_res[1];
   assign rsp_chan.red_out   = lane_res[2];

endmodule

>>> src/bsab_checker.sv
module bsab_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] blue_out,
   input logic [7:0] green_out,
   input logic [7:0] red_out,
   input logic       csr_pready
);

   // a result waiting for the receiver stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its pixel
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(blue_out) && $stable(green_out) &&
                                  $stable(red_out))
      else $error("result changed while stalled");

   // with the output empty the whole pipeline can move
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   // reset empties the pipeline and the bus never waits
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && csr_pready)
      else $error("result or wait state after reset");

endmodule

bind bilinear_scale_alpha_blend bsab_checker u_bsab_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .blue_out  (rsp_chan.blue_out),
   .green_out (rsp_chan.green_out),
   .red_out   (rsp_chan.red_out),
   .csr_pready(csr_pready)
);
